>>> rtl/mesh_radio_frame_parser_top_defines.svh
// Assertion macros used by the port-level checker of the frame parser.
// No dependencies; the asserting module must provide aclk and aresetn.
`ifndef MESH_RADIO_FRAME_PARSER_TOP_DEFINES_SVH
`define MESH_RADIO_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MRFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mrfp_pkg.sv
// Shared types and codes of the mesh radio frame parser.
// No dependencies; every module of the block imports this package.
`default_nettype none

package mrfp_pkg;

    // Parser phases.
    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_TRANSPORT = 3'd1;
    localparam logic [2:0] PH_PATHLEN   = 3'd2;
    localparam logic [2:0] PH_PATH      = 3'd3;
    localparam logic [2:0] PH_PAYLOAD   = 3'd4;
    localparam logic [2:0] PH_ERROR     = 3'd5;

    // Byte classes.
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_TRANSPORT = 3'd1;
    localparam logic [2:0] KIND_PATHLEN   = 3'd2;
    localparam logic [2:0] KIND_PATH      = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd4;
    localparam logic [2:0] KIND_DROPPED   = 3'd5;
    localparam logic [2:0] KIND_IGNORED   = 3'd6;

    // Frame status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BADSIZE  = 3'd2;
    localparam logic [2:0] ST_LONGPATH = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    // Route types that carry two transport codes.
    localparam logic [1:0] ROUTE_TC_FLOOD  = 2'd0;
    localparam logic [1:0] ROUTE_TC_DIRECT = 2'd3;

    // Hash size code that is not allowed.
    localparam logic [1:0] SIZE_CODE_BAD = 2'd3;

    // Number of transport code bytes.
    localparam logic [7:0] TRANSPORT_BYTES = 8'd4;

    // Width of the packed result data word (69 used bits, padded to bytes).
    localparam int unsigned RES_TDATA_W = 72;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  byte_value;
        logic        frame_done;
        logic [2:0]  status;
        logic [1:0]  route_code;
        logic [3:0]  pay_class;
        logic [1:0]  payload_version;
        logic [15:0] transport_code_a;
        logic [15:0] transport_code_b;
        logic [5:0]  hop_count;
        logic [2:0]  hop_size;
        logic [8:0]  payload_count;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/mrfp_decode.sv
// Frame state tracker and per-byte classifier of the frame parser.
// Depends on mrfp_pkg for phase, class and status codes and the result type.
`default_nettype none

module mrfp_decode #(
    parameter int unsigned MAX_PATH    = 64,
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_fire,
    input  wire logic [7:0]      data_byte,
    input  wire logic            frame_last,
    output mrfp_pkg::result_t    result
);
    import mrfp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  field_cnt_reg, field_cnt_next;
    logic [7:0]  path_total_reg, path_total_next;
    logic [7:0]  header_reg, header_next;
    logic [31:0] tcodes_reg, tcodes_next;
    logic [7:0]  pathlen_reg, pathlen_next;
    logic [8:0]  pay_cnt_reg, pay_cnt_next;
    logic [2:0]  err_reg, err_next;

    logic [7:0]  field_inc;
    logic [7:0]  path_total_new;
    logic [2:0]  kind;
    logic [2:0]  status;

    assign field_inc      = field_cnt_reg + 8'd1;
    assign path_total_new = 8'({2'b00, data_byte[5:0]} * ({6'b0, data_byte[7:6]} + 8'd1));

    always_comb begin
        phase_next      = phase_reg;
        field_cnt_next  = field_cnt_reg;
        path_total_next = path_total_reg;
        header_next     = header_reg;
        tcodes_next     = tcodes_reg;
        pathlen_next    = pathlen_reg;
        pay_cnt_next    = pay_cnt_reg;
        err_next        = err_reg;
        kind            = KIND_IGNORED;

        case (phase_reg)
            PH_HEADER: begin
                kind           = KIND_HEADER;
                header_next    = data_byte;
                field_cnt_next = '0;
                if (data_byte[1:0] == ROUTE_TC_FLOOD || data_byte[1:0] == ROUTE_TC_DIRECT) begin
                    phase_next = PH_TRANSPORT;
                end else begin
                    phase_next = PH_PATHLEN;
                end
            end
            PH_TRANSPORT: begin
                kind        = KIND_TRANSPORT;
                tcodes_next = tcodes_reg | (32'(data_byte) << {field_cnt_reg[1:0], 3'b000});
                if (field_inc >= TRANSPORT_BYTES) begin
                    phase_next     = PH_PATHLEN;
                    field_cnt_next = '0;
                end else begin
                    field_cnt_next = field_inc;
                end
            end
            PH_PATHLEN: begin
                kind            = KIND_PATHLEN;
                pathlen_next    = data_byte;
                path_total_next = path_total_new;
                field_cnt_next  = '0;
                if (data_byte[7:6] == SIZE_CODE_BAD) begin
                    err_next   = ST_BADSIZE;
                    phase_next = PH_ERROR;
                end else if (path_total_new > 8'(MAX_PATH)) begin
                    err_next   = ST_LONGPATH;
                    phase_next = PH_ERROR;
                end else if (path_total_new == 8'd0) begin
                    phase_next = PH_PAYLOAD;
                end else begin
                    phase_next = PH_PATH;
                end
            end
            PH_PATH: begin
                kind           = KIND_PATH;
                field_cnt_next = field_inc;
                if (field_inc >= path_total_reg) begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (pay_cnt_reg < 9'(MAX_PAYLOAD)) begin
                    kind         = KIND_PAYLOAD;
                    pay_cnt_next = pay_cnt_reg + 9'd1;
                end else begin
                    kind = KIND_DROPPED;
                end
            end
            default: begin
                kind = KIND_IGNORED;
            end
        endcase

        // Status as the frame would stand if this byte were its last.
        if (err_next != ST_OK) begin
            status = err_next;
        end else if (phase_next == PH_PATH) begin
            status = ST_TRUNC;
        end else if (phase_next == PH_PAYLOAD) begin
            status = ST_OK;
        end else begin
            status = ST_SHORT;
        end

        result            = '0;
        result.byte_kind  = kind;
        result.byte_value = data_byte;
        if (frame_last) begin
            result.frame_done      = 1'b1;
            result.status          = status;
            result.route_code      = header_next[1:0];
            result.pay_class       = header_next[5:2];
            result.payload_version = header_next[7:6];
            if (status != ST_SHORT) begin
                result.transport_code_a = tcodes_next[15:0];
                result.transport_code_b = tcodes_next[31:16];
                result.hop_count        = pathlen_next[5:0];
                result.hop_size         = 3'(pathlen_next[7:6]) + 3'd1;
            end
            if (status == ST_OK) begin
                result.payload_count = pay_cnt_next;
            end

            // The frame is over: everything returns to its idle values.
            phase_next      = PH_HEADER;
            field_cnt_next  = '0;
            path_total_next = '0;
            header_next     = '0;
            tcodes_next     = '0;
            pathlen_next    = '0;
            pay_cnt_next    = '0;
            err_next        = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            field_cnt_reg  <= '0;
            path_total_reg <= '0;
            header_reg     <= '0;
            tcodes_reg     <= '0;
            pathlen_reg    <= '0;
            pay_cnt_reg    <= '0;
            err_reg        <= ST_OK;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            field_cnt_reg  <= field_cnt_next;
            path_total_reg <= path_total_next;
            header_reg     <= header_next;
            tcodes_reg     <= tcodes_next;
            pathlen_reg    <= pathlen_next;
            pay_cnt_reg    <= pay_cnt_next;
            err_reg        <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrfp_out_reg.sv
// Result register with a one-entry skid stage for the frame parser.
// Depends on mrfp_pkg for the result type.
`default_nettype none

module mrfp_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mrfp_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mrfp_pkg::result_t      out_data
);
    import mrfp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    in_fire;
    logic    out_free;

    // The skid stage absorbs the one transaction that can arrive while the
    // result register is held, so input readiness never waits on out_ready.
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/mesh_radio_frame_parser_top.sv
// Mesh radio frame parser: a byte stream in, one classified result per byte out.
// Depends on mrfp_pkg, mrfp_decode and mrfp_out_reg.
//
// Usage: frame bytes enter on the s_ channel in wire order, s_tlast high on the
// final byte of each frame. Every accepted transaction yields exactly one result
// transaction on the m_ channel: m_tuser gives the byte class, m_tdata echoes
// the byte and, on the frame's last byte (m_tlast high), carries the frame
// status and the header, transport, path-length and payload-count fields.
// On other bytes the summary fields are zero.
// An accepted byte is classified combinationally and then registered in the result
// register. Throughput is one byte per cycle while the receiver keeps up, set by
// the state update of the frame tracker followed by the result register.
// A skid stage behind the result register takes one further transaction while
// the receiver stalls; s_tready falls only when both are full, and no result
// is lost or repeated.
// Reset (aresetn low at a rising edge) empties both result stages and puts
// the tracker back to expecting a header byte. The tracker also returns to
// that state after every last byte, so frames follow without gaps.
`default_nettype none

module mesh_radio_frame_parser_top #(
    parameter int unsigned MAX_PATH    = 64,
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // frame_last
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] byte_value, [10:8] status, [12:11] route_code, [16:13] pay_class,
    // [18:17] payload_version, [34:19] transport_code_a, [50:35] transport_code_b,
    // [56:51] hop_count, [59:57] hop_size, [68:60] payload_count, [71:69] zero
    output logic [71:0]      m_tdata,
    output logic [2:0]       m_tuser,   // [2:0] byte_kind
    output logic             m_tlast    // frame_done
);
    import mrfp_pkg::*;

    result_t dec_result;
    result_t out_result;
    logic    in_fire;

    assign in_fire = s_tvalid && s_tready;

    // The tracker advances only on an accepted transaction.
    mrfp_decode #(
        .MAX_PATH    (MAX_PATH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .data_byte  (s_tdata),
        .frame_last (s_tlast),
        .result     (dec_result)
    );

    mrfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (dec_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = RES_TDATA_W'({out_result.payload_count,
                                   out_result.hop_size,
                                   out_result.hop_count,
                                   out_result.transport_code_b,
                                   out_result.transport_code_a,
                                   out_result.payload_version,
                                   out_result.pay_class,
                                   out_result.route_code,
                                   out_result.status,
                                   out_result.byte_value});
    assign m_tuser = out_result.byte_kind;
    assign m_tlast = out_result.frame_done;

endmodule

`default_nettype wire

>>> rtl/mrfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
// Depends on mrfp_pkg and mesh_radio_frame_parser_top_defines.svh.
`default_nettype none

`include "mesh_radio_frame_parser_top_defines.svh"

module mrfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import mrfp_pkg::*;

    // A held result keeps its contents until it is taken.
    `MRFP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // Input back-pressure only arises from a stalled result.
    `MRFP_ASSERT_NOW(a_ready, !s_tready, m_tvalid, "input stalled with no result waiting")

    // Summary fields are zero on every byte but the last of a frame.
    `MRFP_ASSERT_NOW(a_zero_summary, m_tvalid && !m_tlast, m_tdata[68:8] == '0, "summary fields set mid frame")

    // Only a clean frame reports a payload count.
    `MRFP_ASSERT_NOW(a_count_on_ok, m_tvalid && m_tlast && m_tdata[10:8] != ST_OK, m_tdata[68:60] == '0, "payload count on failed frame")

    // A byte ignored after an error ends a frame that failed on its path length.
    `MRFP_ASSERT_NOW(a_ignored_err, m_tvalid && m_tlast && m_tuser == KIND_IGNORED, m_tdata[10:8] == ST_BADSIZE || m_tdata[10:8] == ST_LONGPATH, "ignored byte without path error")

endmodule

bind mesh_radio_frame_parser_top mrfp_checker u_mrfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
